// ===== hw/rtl/lpatg_pkg.sv =====
// ----------------------------------------------------------------------------
// lpatg_pkg
// Shared types, constants and the sine table for the phase accumulator tone
// generator.
// ----------------------------------------------------------------------------
package lpatg_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int MAX_BURST   = 64;

   localparam int IDX_W    = $clog2(TABLE_DEPTH);
   localparam int FRAC_W   = 16;
   localparam int PHASE_W  = IDX_W + FRAC_W;
   localparam int CNT_W    = $clog2(MAX_BURST + 1);

   localparam int INC_W    = 24;
   localparam int MODE_W   = 2;
   localparam int AMP_W    = 7;
   localparam int BURST_W  = 7;
   localparam int SAMPLE_W = 12;

   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 4;
   localparam int REGSEL_W = 2;

   localparam logic [REGSEL_W-1:0] REG_PHASE_INC = 2'd0;
   localparam logic [REGSEL_W-1:0] REG_WAVE_MODE = 2'd1;
   localparam logic [REGSEL_W-1:0] REG_AMPLITUDE = 2'd2;

   localparam logic [MODE_W-1:0] MODE_SINE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd1;

   localparam int AMP_MAX    = 100;
   localparam int FULL_SCALE = 4095;
   localparam int MIDSCALE   = 2048;

   // Datapath widths: table word, amplitude scale, product and quotient.
   localparam int ROM_W       = 32;
   localparam int SCALE_W     = 19;
   localparam int PROD_W      = ROM_W + SCALE_W;
   localparam int PROD_SHIFT  = 33;
   localparam int Y_W         = 17;
   localparam int DIV_K       = 25;
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 22;
   localparam int M_W         = Y_W + RECIP_W;
   localparam int Q_W         = M_W - RECIP_SHIFT;
   localparam int R_W         = Y_W + 1;

   localparam logic [RECIP_W-1:0] RECIP_VAL = RECIP_W'((1 << RECIP_SHIFT) / DIV_K);

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic [ROM_W-1:0] sine_rom_type [TABLE_DEPTH];

   // Unit sine of table point k, offset by one, in Q30.
   function automatic logic [ROM_W-1:0] sine_biased(input int unsigned k);
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] t;
      logic [63:0] mag;
      logic [63:0] biased;
      q  = (64'(k) << 26) / TABLE_DEPTH;
      r  = q & 64'hFF_FFFF;
      x  = q[24] ? ((64'd1 << 24) - r) : r;
      a  = (x * HALF_PI_Q30) >> 24;
      a2 = (a * a) >> 30;
      t  = Q30_ONE - a2 / 72;
      t  = Q30_ONE - ((a2 * t) >> 30) / 42;
      t  = Q30_ONE - ((a2 * t) >> 30) / 20;
      t  = Q30_ONE - ((a2 * t) >> 30) / 6;
      t  = (a * t) >> 30;
      mag = (t > Q30_ONE) ? Q30_ONE : t;
      biased = q[25] ? (Q30_ONE - mag) : (Q30_ONE + mag);
      return ROM_W'(biased);
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         rom[k] = sine_biased(k);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

// ===== hw/rtl/lpatg_if.sv =====
// ----------------------------------------------------------------------------
// lpatg_if
// Valid/ready channels for burst requests and generated samples.
// ----------------------------------------------------------------------------
interface lpatg_req_if;
   logic                             valid;
   logic                             ready;
   logic [lpatg_pkg::BURST_W-1:0]    burst_length;

   modport source (output valid, output burst_length, input ready);
   modport sink   (input valid, input burst_length, output ready);
endinterface

interface lpatg_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lpatg_pkg::SAMPLE_W-1:0]   sample;
   logic                             last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

// ===== hw/rtl/lut_phase_accumulator_tone_generator_core.sv =====
// ----------------------------------------------------------------------------
// lut_phase_accumulator_tone_generator_core
// Table-driven direct digital synthesis tone generator for a 12-bit DAC.
// ----------------------------------------------------------------------------
// A request on req_chan carries a burst length of 1 to 64 samples (larger
// values saturate to 64, zero produces nothing). The block takes a request
// only while no burst is being issued, then issues one sample per cycle
// while rsp_chan is not stalled, and req_chan.ready stays low until the
// last sample of the burst has issued; the burst counter sets the rate.
// Each sample passes a five-stage pipeline: ROM read, amplitude multiply,
// scaling, reciprocal multiply, and a divide-by-25 correction into the
// output register. rsp_chan.last marks the final sample of each burst.
// When rsp_chan.ready is low with a sample waiting, the whole pipeline and
// the issue counter hold; nothing is lost or repeated.
// The APB port (psel .. pready) holds the phase increment (0x0), the
// waveform mode (0x4) and the amplitude in percent (0x8, saturates at 100).
// Write it only while no burst is in flight. Reset clears the phase and
// loads increment 0, sine mode and amplitude 100; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lut_phase_accumulator_tone_generator_core (
   input  logic                               clock,
   input  logic                               reset,
   lpatg_req_if.sink                          req_chan,
   lpatg_rsp_if.source                        rsp_chan,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [lpatg_pkg::ADDR_W-1:0]       paddr,
   input  logic [lpatg_pkg::DATA_W-1:0]       pwdata,
   output logic [lpatg_pkg::DATA_W-1:0]       prdata,
   output logic                               pready
);

   logic [lpatg_pkg::INC_W-1:0]    inc_ff, inc_in;
   logic [lpatg_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [lpatg_pkg::AMP_W-1:0]    amp_ff, amp_in;
   logic [lpatg_pkg::SCALE_W-1:0]  scale_ff, scale_in;

   logic [lpatg_pkg::PHASE_W-1:0]  phase_ff, phase_in;
   logic [lpatg_pkg::CNT_W-1:0]    count_ff, count_in;

   logic                           s1_valid_ff, s1_valid_in;
   logic [lpatg_pkg::ROM_W-1:0]    s1_rom_ff;
   logic                           s1_upper_ff, s1_upper_in;
   logic                           s1_last_ff, s1_last_in;

   logic                           s2_valid_ff, s2_valid_in;
   logic [lpatg_pkg::PROD_W-1:0]   s2_prod_ff, s2_prod_in;
   logic                           s2_upper_ff, s2_upper_in;
   logic                           s2_last_ff, s2_last_in;

   logic                           s3_valid_ff, s3_valid_in;
   logic [lpatg_pkg::Y_W-1:0]      s3_y_ff, s3_y_in;
   logic                           s3_const_ff, s3_const_in;
   logic                           s3_last_ff, s3_last_in;

   logic                           s4_valid_ff, s4_valid_in;
   logic [lpatg_pkg::M_W-1:0]      s4_m_ff, s4_m_in;
   logic [lpatg_pkg::Y_W-1:0]      s4_y_ff, s4_y_in;
   logic                           s4_const_ff, s4_const_in;
   logic                           s4_last_ff, s4_last_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [lpatg_pkg::SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           cfg_write;
   logic [lpatg_pkg::REGSEL_W-1:0] reg_sel;
   logic [lpatg_pkg::AMP_W-1:0]    amp_wr;
   logic                           advance;
   logic                           issue;
   logic                           accept;
   logic [lpatg_pkg::CNT_W-1:0]    burst_sat;
   logic [lpatg_pkg::IDX_W-1:0]    index;
   logic [lpatg_pkg::Q_W-1:0]      out_q0;
   logic [lpatg_pkg::R_W-1:0]      out_rem;
   logic [lpatg_pkg::Q_W-1:0]      out_q;

   // Configuration port
   assign pready    = 1'b1;
   assign reg_sel   = paddr[lpatg_pkg::ADDR_W-1:2];
   assign cfg_write = psel && penable && pwrite && pready;
   assign amp_wr    = (pwdata[lpatg_pkg::AMP_W-1:0] > lpatg_pkg::AMP_W'(lpatg_pkg::AMP_MAX))
                      ? lpatg_pkg::AMP_W'(lpatg_pkg::AMP_MAX)
                      : pwdata[lpatg_pkg::AMP_W-1:0];

   always_comb begin
      unique case (reg_sel)
         lpatg_pkg::REG_PHASE_INC: prdata = lpatg_pkg::DATA_W'(inc_ff);
         lpatg_pkg::REG_WAVE_MODE: prdata = lpatg_pkg::DATA_W'(mode_ff);
         lpatg_pkg::REG_AMPLITUDE: prdata = lpatg_pkg::DATA_W'(amp_ff);
         default:                  prdata = '0;
      endcase
   end

   always_comb begin
      inc_in   = inc_ff;
      mode_in  = mode_ff;
      amp_in   = amp_ff;
      scale_in = scale_ff;
      if (cfg_write) begin
         unique case (reg_sel)
            lpatg_pkg::REG_PHASE_INC: inc_in  = pwdata[lpatg_pkg::INC_W-1:0];
            lpatg_pkg::REG_WAVE_MODE: mode_in = pwdata[lpatg_pkg::MODE_W-1:0];
            lpatg_pkg::REG_AMPLITUDE: begin
               amp_in   = amp_wr;
               scale_in = lpatg_pkg::SCALE_W'(lpatg_pkg::FULL_SCALE * int'(amp_wr));
            end
            default: ;
         endcase
      end
   end

   // Issue control
   assign advance   = !rsp_valid_ff || rsp_chan.ready;
   assign issue     = advance && (count_ff != '0);
   assign req_chan.ready = (count_ff == '0);
   assign accept    = req_chan.valid && req_chan.ready;
   assign burst_sat = (req_chan.burst_length > lpatg_pkg::BURST_W'(lpatg_pkg::MAX_BURST))
                      ? lpatg_pkg::CNT_W'(lpatg_pkg::MAX_BURST)
                      : lpatg_pkg::CNT_W'(req_chan.burst_length);
   assign index     = phase_ff[lpatg_pkg::PHASE_W-1:lpatg_pkg::FRAC_W];

   always_comb begin
      count_in = count_ff;
      phase_in = phase_ff;
      if (accept) begin
         count_in = burst_sat;
      end else if (issue) begin
         count_in = count_ff - 1'b1;
      end
      if (issue) begin
         phase_in = phase_ff + lpatg_pkg::PHASE_W'(inc_ff);
      end
   end

   // Output divide-by-25 correction
   assign out_q0  = s4_m_ff[lpatg_pkg::M_W-1:lpatg_pkg::RECIP_SHIFT];
   assign out_rem = lpatg_pkg::R_W'(s4_y_ff)
                    - lpatg_pkg::R_W'(out_q0) * lpatg_pkg::R_W'(lpatg_pkg::DIV_K);
   assign out_q   = (out_rem >= lpatg_pkg::R_W'(lpatg_pkg::DIV_K)) ? out_q0 + 1'b1 : out_q0;

   // Pipeline next values
   always_comb begin
      s1_valid_in   = issue;
      s1_upper_in   = index[lpatg_pkg::IDX_W-1];
      s1_last_in    = (count_ff == lpatg_pkg::CNT_W'(1));

      s2_valid_in   = s1_valid_ff;
      s2_prod_in    = lpatg_pkg::PROD_W'(s1_rom_ff) * lpatg_pkg::PROD_W'(scale_ff);
      s2_upper_in   = s1_upper_ff;
      s2_last_in    = s1_last_ff;

      s3_valid_in   = s2_valid_ff;
      s3_last_in    = s2_last_ff;
      s3_const_in   = 1'b0;
      if (mode_ff == lpatg_pkg::MODE_SINE) begin
         s3_y_in = s2_prod_ff[lpatg_pkg::PROD_SHIFT+lpatg_pkg::Y_W-1:lpatg_pkg::PROD_SHIFT];
      end else if (mode_ff == lpatg_pkg::MODE_SQUARE) begin
         s3_y_in = s2_upper_ff ? '0 : scale_ff[lpatg_pkg::Y_W+1:2];
      end else begin
         s3_y_in     = '0;
         s3_const_in = 1'b1;
      end

      s4_valid_in   = s3_valid_ff;
      s4_m_in       = lpatg_pkg::M_W'(s3_y_ff) * lpatg_pkg::M_W'(lpatg_pkg::RECIP_VAL);
      s4_y_in       = s3_y_ff;
      s4_const_in   = s3_const_ff;
      s4_last_in    = s3_last_ff;

      rsp_valid_in  = s4_valid_ff;
      rsp_sample_in = s4_const_ff ? lpatg_pkg::SAMPLE_W'(lpatg_pkg::MIDSCALE)
                                  : out_q[lpatg_pkg::SAMPLE_W-1:0];
      rsp_last_in   = s4_last_ff;
   end

   // Sine ROM, registered read
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_rom_ff <= lpatg_pkg::SINE_ROM[index];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff       <= '0;
         mode_ff      <= lpatg_pkg::MODE_SINE;
         amp_ff       <= lpatg_pkg::AMP_W'(lpatg_pkg::AMP_MAX);
         scale_ff     <= lpatg_pkg::SCALE_W'(lpatg_pkg::FULL_SCALE * lpatg_pkg::AMP_MAX);
         phase_ff     <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         inc_ff   <= inc_in;
         mode_ff  <= mode_in;
         amp_ff   <= amp_in;
         scale_ff <= scale_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         if (advance) begin
            s1_valid_ff  <= s1_valid_in;
            s2_valid_ff  <= s2_valid_in;
            s3_valid_ff  <= s3_valid_in;
            s4_valid_ff  <= s4_valid_in;
            rsp_valid_ff <= rsp_valid_in;
         end
      end
   end

   // Hold payload while the receiver stalls
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_upper_ff   <= s1_upper_in;
         s1_last_ff    <= s1_last_in;
         s2_prod_ff    <= s2_prod_in;
         s2_upper_ff   <= s2_upper_in;
         s2_last_ff    <= s2_last_in;
         s3_y_ff       <= s3_y_in;
         s3_const_ff   <= s3_const_in;
         s3_last_ff    <= s3_last_in;
         s4_m_ff       <= s4_m_in;
         s4_y_ff       <= s4_y_in;
         s4_const_ff   <= s4_const_in;
         s4_last_ff    <= s4_last_in;
         rsp_sample_ff <= rsp_sample_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.sample = rsp_sample_ff;
   assign rsp_chan.last   = rsp_last_ff;

`ifndef SYNTHESIS
   a_phase_holds: assert property (@(posedge clock) disable iff (reset)
      !issue |=> phase_ff == $past(phase_ff))
      else $error("phase moved without a sample issue");

   a_burst_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> count_ff == $past(burst_sat))
      else $error("burst counter not loaded with saturated length");

   a_div_residual: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> out_rem < lpatg_pkg::R_W'(2 * lpatg_pkg::DIV_K))
      else $error("reciprocal quotient off by more than one");

   a_no_issue_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready && count_ff != '0) |=> count_ff == $past(count_ff))
      else $error("burst counter advanced during output stall");
`endif

endmodule

// ===== tb/lut_phase_accumulator_tone_generator_core_tb.sv =====
// ----------------------------------------------------------------------------
// lut_phase_accumulator_tone_generator_core_tb
// Self-checking bench for the tone generator. Burst requests go in under
// several register settings, with random idle cycles on both channels. A
// local model of the phase accumulator and the sine, square and midscale
// shapes predicts every sample and its last flag, and each sample that comes
// out is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module lut_phase_accumulator_tone_generator_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [lpatg_pkg::SAMPLE_W-1:0] sample;
      logic                           last;
   } dac_word_type;

   localparam logic [lpatg_pkg::REGSEL_W-1:0] REG_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 12;

   logic clock = 1'b0;
   logic reset;

   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [lpatg_pkg::ADDR_W-1:0] paddr;
   logic [lpatg_pkg::DATA_W-1:0] pwdata;
   logic [lpatg_pkg::DATA_W-1:0] prdata;
   logic                         pready;

   lpatg_req_if req_bus ();
   lpatg_rsp_if rsp_bus ();

   lut_phase_accumulator_tone_generator_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   logic [lpatg_pkg::INC_W-1:0]   tone_step;
   logic [lpatg_pkg::MODE_W-1:0]  tone_shape;
   logic [lpatg_pkg::AMP_W-1:0]   tone_level;
   logic [lpatg_pkg::PHASE_W-1:0] tone_phase;

   logic [lpatg_pkg::BURST_W-1:0] pending_bursts[$];
   dac_word_type                  expected_words[$];
   logic                          req_taken = 1'b0;
   int unsigned                   send_idle_pct;
   int unsigned                   hold_idle_pct;
   int unsigned                   fault_count = 0;

   always #4 clock = ~clock;

   function automatic logic [lpatg_pkg::SAMPLE_W-1:0] sine_code(
         input logic [lpatg_pkg::IDX_W-1:0] k,
         input logic [lpatg_pkg::AMP_W-1:0] pct);
      logic [63:0] ang;
      logic [63:0] quarter;
      logic [63:0] frac;
      logic [63:0] fold;
      logic [63:0] theta;
      logic [63:0] th2;
      logic [63:0] poly;
      logic [63:0] mag;
      logic [63:0] level;
      ang     = (64'(k) << 26) / lpatg_pkg::TABLE_DEPTH;
      quarter = (ang >> 24) & 64'd3;
      frac    = ang & 64'hFF_FFFF;
      fold    = quarter[0] ? ((64'd1 << 24) - frac) : frac;
      theta   = (fold * lpatg_pkg::HALF_PI_Q30) >> 24;
      th2     = (theta * theta) >> 30;
      poly    = lpatg_pkg::Q30_ONE - th2 / 72;
      poly    = lpatg_pkg::Q30_ONE - ((th2 * poly) >> 30) / 42;
      poly    = lpatg_pkg::Q30_ONE - ((th2 * poly) >> 30) / 20;
      poly    = lpatg_pkg::Q30_ONE - ((th2 * poly) >> 30) / 6;
      poly    = (theta * poly) >> 30;
      mag     = (poly > lpatg_pkg::Q30_ONE) ? lpatg_pkg::Q30_ONE : poly;
      level   = quarter[1] ? (lpatg_pkg::Q30_ONE - mag) : (lpatg_pkg::Q30_ONE + mag);
      return lpatg_pkg::SAMPLE_W'((level * 64'd4095 * 64'(pct))
                                  / (64'd200 * lpatg_pkg::Q30_ONE));
   endfunction

   function automatic logic [lpatg_pkg::SAMPLE_W-1:0] dac_code(
         input logic [lpatg_pkg::IDX_W-1:0] k);
      case (tone_shape)
         lpatg_pkg::MODE_SINE: begin
            return sine_code(k, tone_level);
         end
         lpatg_pkg::MODE_SQUARE: begin
            return (k < lpatg_pkg::TABLE_DEPTH / 2)
                   ? lpatg_pkg::SAMPLE_W'((lpatg_pkg::FULL_SCALE * tone_level)
                                          / lpatg_pkg::AMP_MAX)
                   : '0;
         end
         default: begin
            return lpatg_pkg::SAMPLE_W'(lpatg_pkg::MIDSCALE);
         end
      endcase
   endfunction

   task automatic predict_burst(input logic [lpatg_pkg::BURST_W-1:0] len);
      int unsigned  count;
      dac_word_type word;
      count = (len > lpatg_pkg::MAX_BURST) ? lpatg_pkg::MAX_BURST : len;
      for (int unsigned i = 0; i < count; i++) begin
         word.sample = dac_code(tone_phase[lpatg_pkg::PHASE_W-1:lpatg_pkg::FRAC_W]);
         word.last   = (i + 1 == count);
         expected_words.push_back(word);
         tone_phase = tone_phase + lpatg_pkg::PHASE_W'(tone_step);
      end
   endtask

   function automatic logic [lpatg_pkg::BURST_W-1:0] random_burst_length();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 6) return '0;
      else if (pick < 12) return lpatg_pkg::BURST_W'($urandom_range(127, 65));
      else if (pick < 20) return lpatg_pkg::BURST_W'(lpatg_pkg::MAX_BURST);
      else if (pick < 60) return lpatg_pkg::BURST_W'($urandom_range(8, 1));
      else return lpatg_pkg::BURST_W'($urandom_range(lpatg_pkg::MAX_BURST - 1, 1));
   endfunction

   task automatic csr_write(input logic [lpatg_pkg::REGSEL_W-1:0] sel,
                            input logic [lpatg_pkg::DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= lpatg_pkg::ADDR_W'({sel, 2'b00});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (sel)
         lpatg_pkg::REG_PHASE_INC: tone_step = value[lpatg_pkg::INC_W-1:0];
         lpatg_pkg::REG_WAVE_MODE: tone_shape = value[lpatg_pkg::MODE_W-1:0];
         lpatg_pkg::REG_AMPLITUDE: tone_level =
            (value[lpatg_pkg::AMP_W-1:0] > lpatg_pkg::AMP_MAX)
            ? lpatg_pkg::AMP_W'(lpatg_pkg::AMP_MAX)
            : value[lpatg_pkg::AMP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic settle();
      @(posedge clock);
      while (pending_bursts.size() != 0 || req_bus.valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver and sample backpressure
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!req_bus.valid || req_taken) begin
            if (pending_bursts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_bus.valid        <= 1'b1;
               req_bus.burst_length <= pending_bursts.pop_front();
            end else begin
               req_bus.valid        <= 1'b0;
               req_bus.burst_length <= lpatg_pkg::BURST_W'($urandom);
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= hold_idle_pct);
      end
   end

   // accepted requests and samples
   always @(posedge clock) begin
      dac_word_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predict_burst(req_bus.burst_length);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected sample, expected none, actual sample %0d last %0b",
                        $realtime, rsp_bus.sample, rsp_bus.last);
               fault_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_bus.sample !== want.sample) begin
                  $display("%0t: sample mismatch, expected %0d actual %0d",
                           $realtime, want.sample, rsp_bus.sample);
                  fault_count++;
               end
               if (rsp_bus.last !== want.last) begin
                  $display("%0t: last mismatch, expected %0b actual %0b",
                           $realtime, want.last, rsp_bus.last);
                  fault_count++;
               end
            end
         end
      end
      req_taken <= req_bus.valid && req_bus.ready;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [lpatg_pkg::DATA_W-1:0] step_val;
      logic [lpatg_pkg::DATA_W-1:0] level_val;
      reset                = 1'b1;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_bus.valid        = 1'b0;
      req_bus.burst_length = '0;
      rsp_bus.ready        = 1'b0;
      send_idle_pct        = 26;
      hold_idle_pct        = 65;
      tone_step            = '0;
      tone_shape           = lpatg_pkg::MODE_SINE;
      tone_level           = lpatg_pkg::AMP_W'(lpatg_pkg::AMP_MAX);
      tone_phase           = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: increment zero, sine at full amplitude
      pending_bursts.push_back(7'd1);
      pending_bursts.push_back(7'd3);
      settle();

      // one table point per sample, whole sine period, saturated and empty bursts
      csr_write(lpatg_pkg::REG_PHASE_INC, 32'h0001_0000);
      pending_bursts.push_back(7'd64);
      pending_bursts.push_back(7'd127);
      pending_bursts.push_back(7'd0);
      pending_bursts.push_back(7'd65);
      pending_bursts.push_back(7'd64);
      settle();

      // spare register, masked increment, amplitude above full scale
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      csr_write(lpatg_pkg::REG_PHASE_INC, 32'hFFFF_FFFF);
      csr_write(lpatg_pkg::REG_WAVE_MODE, 32'h0000_0001);
      csr_write(lpatg_pkg::REG_AMPLITUDE, 32'h0000_007F);
      pending_bursts.push_back(7'd64);
      pending_bursts.push_back(7'd2);
      settle();

      csr_write(lpatg_pkg::REG_WAVE_MODE, 32'h0000_0000);
      csr_write(lpatg_pkg::REG_AMPLITUDE, 32'h0000_0000);
      pending_bursts.push_back(7'd5);
      settle();

      csr_write(lpatg_pkg::REG_WAVE_MODE, 32'h0000_0003);
      csr_write(lpatg_pkg::REG_AMPLITUDE, 32'hFFFF_FF32);
      pending_bursts.push_back(7'd63);
      settle();

      csr_write(lpatg_pkg::REG_WAVE_MODE, 32'h0000_0002);
      csr_write(lpatg_pkg::REG_PHASE_INC, 32'h0012_3456);
      pending_bursts.push_back(7'd7);
      settle();

      csr_write(lpatg_pkg::REG_WAVE_MODE, 32'hFFFF_FFFD);
      csr_write(lpatg_pkg::REG_AMPLITUDE, 32'h0000_0001);
      csr_write(lpatg_pkg::REG_PHASE_INC, 32'h0080_0000);
      pending_bursts.push_back(7'd4);
      pending_bursts.push_back(7'd42);
      settle();

      for (int p = 0; p < 10; p++) begin
         if (p == 3) begin
            send_idle_pct = 65;
            hold_idle_pct = 26;
         end else if (p == 6) begin
            send_idle_pct = 0;
            hold_idle_pct = 0;
         end
         if (p == 0) step_val = 32'h00FF_FFFF;
         else if (p == 1) step_val = 32'h0000_0000;
         else if (p == 2) step_val = 32'h0001_0000;
         else if (p % 2 == 0) step_val = $urandom_range(32'h0003_FFFF);
         else step_val = $urandom;
         if (p == 0) level_val = lpatg_pkg::AMP_MAX;
         else if (p == 1) level_val = 0;
         else if (p == 2) level_val = 127;
         else level_val = $urandom_range(127);
         csr_write(lpatg_pkg::REG_PHASE_INC, step_val);
         csr_write(lpatg_pkg::REG_WAVE_MODE, lpatg_pkg::DATA_W'(p % 4));
         csr_write(lpatg_pkg::REG_AMPLITUDE, level_val);
         repeat (34) pending_bursts.push_back(random_burst_length());
         settle();
      end

      if (fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
